[design/dda_pkg.sv]
// Package: shared constants and controller/datapath interface types for the DDA rasterizer.
`timescale 1ns / 1ps

package dda_pkg;

  localparam int unsigned DDA_COORD_BITS = 6;
  localparam int unsigned DDA_FRAC_BITS  = 16;
  localparam int unsigned DDA_COLOR_BITS = 24;

  typedef struct packed {
    logic start;     // load a new segment from the input transaction
    logic div_step;  // one restoring-division step on both increments
    logic emit;      // load the output register with the current pixel, advance
  } dda_cmd_t;

  typedef struct packed {
    logic steps_zero;  // input segment has equal endpoints
    logic div_done;    // this division step is the final one
    logic last_pix;    // current pixel is the final pixel of the segment
  } dda_sts_t;

endpackage

[design/dda_ctrl.sv]
// Controller: sequences segment load, serial division and pixel emission.
`timescale 1ns / 1ps

module dda_ctrl
  import dda_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dda_sts_t sts,
  output dda_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.start    = (state == S_IDLE) && in_valid;
    cmd.div_step = (state == S_DIV);
    cmd.emit     = (state == S_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state <= sts.steps_zero ? S_EMIT : S_DIV;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (cmd.emit && sts.last_pix) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/dda_dp.sv]
// Datapath: deltas, dual bit-serial divider, position accumulators and output register.
`timescale 1ns / 1ps

module dda_dp
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = DDA_COORD_BITS,
  parameter int unsigned FRAC_BITS  = DDA_FRAC_BITS
) (
  input  logic                      clk,
  input  dda_cmd_t                  cmd,
  output dda_sts_t                  sts,
  input  logic [COORD_BITS-1:0]     x_start,
  input  logic [COORD_BITS-1:0]     y_start,
  input  logic [COORD_BITS-1:0]     x_end,
  input  logic [COORD_BITS-1:0]     y_end,
  input  logic [DDA_COLOR_BITS-1:0] color,
  output logic [COORD_BITS-1:0]     pixel_x,
  output logic [COORD_BITS-1:0]     pixel_y,
  output logic [DDA_COLOR_BITS-1:0] pixel_color,
  output logic                      last
);

  localparam int unsigned W  = COORD_BITS + FRAC_BITS;
  localparam int unsigned CW = $clog2(W);
  localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

  // segment registers
  logic [COORD_BITS-1:0]     steps;
  logic [COORD_BITS-1:0]     k;
  logic                      sx, sy;
  logic [W-1:0]              xpos, ypos;
  logic [DDA_COLOR_BITS-1:0] seg_color;

  // divider: dividend shifts out of qx/qy while quotient bits shift in
  logic [W-1:0]          qx, qy;
  logic [COORD_BITS-1:0] rx, ry;
  logic [CW-1:0]         dcnt;

  logic                  dx_neg, dy_neg;
  logic [COORD_BITS-1:0] adx, ady, steps_in;
  logic [COORD_BITS:0]   rx_sh, ry_sh;
  logic                  gex, gey;
  logic [W-1:0]          xround, yround;

  always_comb begin
    dx_neg   = x_end < x_start;
    dy_neg   = y_end < y_start;
    adx      = dx_neg ? (x_start - x_end) : (x_end - x_start);
    ady      = dy_neg ? (y_start - y_end) : (y_end - y_start);
    steps_in = (adx > ady) ? adx : ady;

    rx_sh = {rx, qx[W-1]};
    ry_sh = {ry, qy[W-1]};
    gex   = rx_sh >= {1'b0, steps};
    gey   = ry_sh >= {1'b0, steps};

    xround = xpos + HALF;
    yround = ypos + HALF;

    sts            = '0;
    sts.steps_zero = (x_start == x_end) && (y_start == y_end);
    sts.div_done   = (dcnt == CW'(W - 1));
    sts.last_pix   = (k == steps);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      steps     <= steps_in;
      k         <= '0;
      sx        <= dx_neg;
      sy        <= dy_neg;
      xpos      <= {x_start, {FRAC_BITS{1'b0}}};
      ypos      <= {y_start, {FRAC_BITS{1'b0}}};
      seg_color <= color;
      qx        <= sts.steps_zero ? '0 : {adx, {FRAC_BITS{1'b0}}};
      qy        <= sts.steps_zero ? '0 : {ady, {FRAC_BITS{1'b0}}};
      rx        <= '0;
      ry        <= '0;
      dcnt      <= '0;
    end else if (cmd.div_step) begin
      qx   <= {qx[W-2:0], gex};
      qy   <= {qy[W-2:0], gey};
      rx   <= gex ? COORD_BITS'(rx_sh - {1'b0, steps}) : rx_sh[COORD_BITS-1:0];
      ry   <= gey ? COORD_BITS'(ry_sh - {1'b0, steps}) : ry_sh[COORD_BITS-1:0];
      dcnt <= dcnt + 1'b1;
    end else if (cmd.emit) begin
      pixel_x     <= xround[W-1:FRAC_BITS];
      pixel_y     <= yround[W-1:FRAC_BITS];
      pixel_color <= seg_color;
      last        <= sts.last_pix;
      xpos        <= sx ? (xpos - qx) : (xpos + qx);
      ypos        <= sy ? (ypos - qy) : (ypos + qy);
      k           <= k + 1'b1;
    end
  end

endmodule

[design/dda_line_rasterizer_unit.sv]
// Top level: DDA line rasterizer, controller plus datapath.
`timescale 1ns / 1ps

// Takes one segment per input transaction and emits steps+1 pixel transactions,
// steps = max(|dx|, |dy|), the final one flagged by last. After a segment is
// accepted, a bit-serial restoring divider computes both increments, then one
// pixel leaves per cycle while out_ready holds. Equal endpoints skip the
// division and give one pixel. The next segment is taken in the cycle after
// its last pixel enters the output register.
module dda_line_rasterizer_unit
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = DDA_COORD_BITS,
  parameter int unsigned FRAC_BITS  = DDA_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COORD_BITS-1:0]     x_start,
  input  logic [COORD_BITS-1:0]     y_start,
  input  logic [COORD_BITS-1:0]     x_end,
  input  logic [COORD_BITS-1:0]     y_end,
  input  logic [DDA_COLOR_BITS-1:0] color,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COORD_BITS-1:0]     pixel_x,
  output logic [COORD_BITS-1:0]     pixel_y,
  output logic [DDA_COLOR_BITS-1:0] pixel_color,
  output logic                      last
);

  dda_cmd_t cmd;
  dda_sts_t sts;

  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dda_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .color       (color),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last        (last)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a segment is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("pending pixel overwritten");

  a_div_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !in_ready && !cmd.emit)
    else $error("division step overlaps idle or emit");
`endif

endmodule

[sim/dda_line_rasterizer_unit_tb.sv]
// Testbench: random and directed line segments checked pixel by pixel against a DDA predictor.
`timescale 1ns / 1ps

module dda_line_rasterizer_unit_tb;
  import dda_pkg::*;

  localparam int CW = DDA_COORD_BITS;
  localparam int FW = DDA_FRAC_BITS;
  localparam int COLW = DDA_COLOR_BITS;
  localparam int RANDOM_SEGMENTS = 350;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT = 5_000_000;

  typedef struct packed {
    logic [CW-1:0]   x;
    logic [CW-1:0]   y;
    logic [COLW-1:0] color;
    logic            last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t expected_pixels[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function longint step_increment(longint delta, longint steps);
      longint mag;
      longint q;
      mag = (delta < 0) ? -delta : delta;
      q = (mag << FW) / steps;
      return (delta < 0) ? -q : q;
    endfunction

    function logic [CW-1:0] round_coord(longint pos);
      longint r;
      if (pos < 0) pos = 0;
      r = (pos + (longint'(1) << (FW - 1))) >>> FW;
      return r[CW-1:0];
    endfunction

    // Expand one accepted segment into its expected pixel transactions.
    function void note_segment(logic [CW-1:0] xs, logic [CW-1:0] ys, logic [CW-1:0] xe,
                               logic [CW-1:0] ye, logic [COLW-1:0] c);
      longint x0, y0, x1, y1, dx, dy, adx, ady, steps, xinc, yinc, xpos, ypos;
      pixel_t p;
      x0 = xs;
      y0 = ys;
      x1 = xe;
      y1 = ye;
      dx = x1 - x0;
      dy = y1 - y0;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      steps = (adx > ady) ? adx : ady;
      xinc = 0;
      yinc = 0;
      if (steps > 0) begin
        xinc = step_increment(dx, steps);
        yinc = step_increment(dy, steps);
      end
      xpos = x0 << FW;
      ypos = y0 << FW;
      for (longint k = 0; k <= steps; k++) begin
        p.x = round_coord(xpos);
        p.y = round_coord(ypos);
        p.color = c;
        p.last = (k == steps);
        expected_pixels.push_back(p);
        xpos += xinc;
        ypos += yinc;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_pix;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d color=%06h last=%0b", $time,
                 got.x, got.y, got.color, got.last);
        return;
      end
      exp_pix = expected_pixels.pop_front();
      if (got !== exp_pix) begin
        errors++;
        $display({"%0t: pixel mismatch expected x=%0d y=%0d color=%06h last=%0b,",
                  " got x=%0d y=%0d color=%06h last=%0b"},
                 $time, exp_pix.x, exp_pix.y, exp_pix.color, exp_pix.last,
                 got.x, got.y, got.color, got.last);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  logic [CW-1:0]   x_start;
  logic [CW-1:0]   y_start;
  logic [CW-1:0]   x_end;
  logic [CW-1:0]   y_end;
  logic [COLW-1:0] color;
  logic            out_valid;
  logic            out_ready;
  logic [CW-1:0]   pixel_x;
  logic [CW-1:0]   pixel_y;
  logic [COLW-1:0] pixel_color;
  logic            last;

  pixel_scoreboard sb = new();
  int holds_requested = 0;
  int holds_served = 0;
  int cycle_count = 0;

  dda_line_rasterizer_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .color(color),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_color(pixel_color),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  function automatic logic [CW-1:0] near_coord(logic [CW-1:0] base, int span);
    int v;
    v = int'(base) + $urandom_range(0, 2 * span) - span;
    if (v < 0) v = 0;
    if (v > (1 << CW) - 1) v = (1 << CW) - 1;
    return v[CW-1:0];
  endfunction

  task automatic send_segment(input logic [CW-1:0] xs, input logic [CW-1:0] ys,
                              input logic [CW-1:0] xe, input logic [CW-1:0] ye,
                              input logic [COLW-1:0] c);
    int gap;
    in_valid <= 1'b1;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    color <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_segment(xs, ys, xe, ye, c);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_segment();
    logic [CW-1:0] xs, ys, xe, ye;
    int kind;
    int d;
    xs = CW'($urandom);
    ys = CW'($urandom);
    xe = CW'($urandom);
    ye = CW'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        xe = xs;
        ye = ys;
      end
      1, 2, 3: begin
        xe = near_coord(xs, 4);
        ye = near_coord(ys, 4);
      end
      4: begin
        if ($urandom_range(0, 1)) xe = xs;
        else ye = ys;
      end
      5: begin
        d = $urandom_range(0, 20);
        xe = CW'(int'(near_coord(xs, 0)) + (($urandom_range(0, 1)) ? d : -d));
        ye = CW'(int'(ys) + (($urandom_range(0, 1)) ? d : -d));
      end
      default: ;
    endcase
    send_segment(xs, ys, xe, ye, COLW'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_pixel('{x: pixel_x, y: pixel_y, color: pixel_color, last: last});
    end
  end

  initial begin : receiver
    int run;
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_served < holds_requested) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    in_valid <= 1'b0;
    x_start <= '0;
    y_start <= '0;
    x_end <= '0;
    y_end <= '0;
    color <= '0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // corners, diagonals, axes, single points, all octants
    send_segment(6'd0, 6'd0, 6'd63, 6'd63, 24'h000000);
    send_segment(6'd63, 6'd63, 6'd0, 6'd0, 24'hFFFFFF);
    send_segment(6'd0, 6'd63, 6'd63, 6'd0, 24'hAAAAAA);
    send_segment(6'd63, 6'd0, 6'd0, 6'd63, 24'h555555);
    send_segment(6'd0, 6'd10, 6'd63, 6'd10, 24'hFF0000);
    send_segment(6'd63, 6'd50, 6'd0, 6'd50, 24'h00FF00);
    send_segment(6'd20, 6'd0, 6'd20, 6'd63, 24'h0000FF);
    send_segment(6'd40, 6'd63, 6'd40, 6'd0, 24'h123456);
    send_segment(6'd0, 6'd0, 6'd0, 6'd0, 24'h000000);
    send_segment(6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF);
    send_segment(6'd17, 6'd42, 6'd17, 6'd42, 24'hABCDEF);
    send_segment(6'd10, 6'd10, 6'd50, 6'd17, 24'h0F0F0F);
    send_segment(6'd10, 6'd10, 6'd17, 6'd50, 24'hF0F0F0);
    send_segment(6'd50, 6'd10, 6'd10, 6'd17, 24'h800001);
    send_segment(6'd50, 6'd10, 6'd43, 6'd50, 24'h7FFFFE);
    send_segment(6'd50, 6'd50, 6'd10, 6'd43, 24'h3C3C3C);
    send_segment(6'd50, 6'd50, 6'd43, 6'd10, 24'hC3C3C3);
    send_segment(6'd10, 6'd50, 6'd50, 6'd43, 24'h010203);
    send_segment(6'd10, 6'd50, 6'd17, 6'd10, 24'h040506);
    send_segment(6'd0, 6'd0, 6'd63, 6'd1, 24'h999999);
    send_segment(6'd0, 6'd0, 6'd1, 6'd63, 24'h666666);
    send_segment(6'd5, 6'd5, 6'd6, 6'd6, 24'hFEDCBA);
    send_segment(6'd0, 6'd0, 6'd3, 6'd2, 24'h111111);

    for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
      if (i == 100) holds_requested++;
      if (i == 200) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
      end
      send_random_segment();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
